/* hdl/psrs_pkg.sv */
`timescale 1ns / 1ps

package psrs_pkg;

  // Widths of the byte counter, the run length counter and the found counter.
  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int COUNT_BITS  = 32;

  // Printable range, the blank character and the zero byte.
  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0] LAST_PRINTABLE  = 8'd126;
  localparam logic [7:0] SPACE_CHAR      = 8'd32;
  localparam logic [7:0] ZERO_BYTE       = 8'd0;

  // Configuration port address width: two word registers.
  localparam int ADDR_BITS = 3;

  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

  typedef struct packed {
    logic       char_mode;
    logic [7:0] min_length;
  } cfg_t;

  typedef struct packed {
    logic                   string_found;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LENGTH_BITS-1:0] char_count;
    logic [COUNT_BITS-1:0]  total_found;
    logic                   stream_done;
  } result_t;

endpackage

/* hdl/printable_string_run_scanner.sv */
`timescale 1ns / 1ps

// Scans a byte stream for runs of printable characters (codes 32 to 126),
// as single bytes or as UTF-16LE pairs selected by char_mode, and reports
// each run of at least min_length characters that holds a non-space
// character with its start offset, length (saturating at 65535) and the
// running count of runs found. A byte marked end_of_stream flushes the run,
// always gives one result with stream_done set, and clears offset and count.
// One byte is accepted every cycle while in_stall is low; a byte passes an
// input register and then the result register before its result is offered.
// The rate is set by the scan state update.
// Configuration is written over the APB port: char_mode at address 0,
// min_length at address 4.
module printable_string_run_scanner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psrs_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              end_of_stream,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              string_found,
  output logic [psrs_pkg::OFFSET_BITS-1:0]  start_offset,
  output logic [psrs_pkg::LENGTH_BITS-1:0]  char_count,
  output logic [psrs_pkg::COUNT_BITS-1:0]   total_found,
  output logic                              stream_done
);
  import psrs_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    out_free;

  psrs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psrs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  psrs_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .string_found (string_found),
    .start_offset (start_offset),
    .char_count   (char_count),
    .total_found  (total_found),
    .stream_done  (stream_done)
  );

endmodule

/* hdl/psrs_regs.sv */
`timescale 1ns / 1ps

module psrs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psrs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output psrs_pkg::cfg_t                cfg
);
  import psrs_pkg::*;

  typedef enum logic [0:0] {
    REG_CHAR_MODE  = 1'b0,
    REG_MIN_LENGTH = 1'b1
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.char_mode  <= 1'b0;
      cfg.min_length <= 8'd4;
    end else if (wr_en) begin
      case (idx)
        REG_CHAR_MODE:  cfg.char_mode  <= pwdata[0];
        REG_MIN_LENGTH: cfg.min_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (idx)
      REG_CHAR_MODE:  prdata = {31'd0, cfg.char_mode};
      REG_MIN_LENGTH: prdata = {24'd0, cfg.min_length};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/psrs_core.sv */
`timescale 1ns / 1ps

module psrs_core (
  input  logic              clk,
  input  logic              rst,
  input  psrs_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  input  logic              out_free,
  output logic              res_valid,
  output psrs_pkg::result_t res
);
  import psrs_pkg::*;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eos;

  // Scan state.
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] run_start;
  logic [LENGTH_BITS-1:0] run_length;
  logic                   run_has_nonspace;
  logic                   pending_valid;
  logic                   pending_nonspace;
  logic [OFFSET_BITS-1:0] pending_position;
  logic [COUNT_BITS-1:0]  found_count;

  logic [OFFSET_BITS-1:0] run_start_next;
  logic [LENGTH_BITS-1:0] run_length_next;
  logic                   run_has_nonspace_next;
  logic                   pending_valid_next;
  logic                   pending_nonspace_next;
  logic [OFFSET_BITS-1:0] pending_position_next;
  logic [COUNT_BITS-1:0]  found_count_next;

  logic                   step;
  logic                   printable;
  logic                   nonspace;
  logic                   do_add;
  logic [OFFSET_BITS-1:0] add_pos;
  logic                   add_ns;
  logic                   do_flush;
  logic                   hit;
  logic [LENGTH_BITS-1:0] min_len;
  logic [OFFSET_BITS-1:0] rs_a;
  logic [LENGTH_BITS-1:0] rl_a;
  logic                   rn_a;
  logic [OFFSET_BITS-1:0] flush_start;
  logic [LENGTH_BITS-1:0] flush_length;
  logic                   flush_ns;

  assign in_stall = s1_valid && !out_free;
  assign step     = s1_valid && out_free;
  assign min_len  = {{(LENGTH_BITS-8){1'b0}}, cfg.min_length};

  // Capture a transaction whenever the input register is free to move.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= data_byte;
      s1_eos  <= end_of_stream;
    end
  end

  assign printable = (s1_byte >= FIRST_PRINTABLE) && (s1_byte <= LAST_PRINTABLE);
  assign nonspace  = s1_byte != SPACE_CHAR;

  // Decide whether this byte adds a character, ends the run or is held as the first byte of a pair.
  always_comb begin
    do_add                = 1'b0;
    add_pos               = byte_position;
    add_ns                = nonspace;
    do_flush              = 1'b0;
    pending_valid_next    = pending_valid;
    pending_nonspace_next = pending_nonspace;
    pending_position_next = pending_position;
    if (!cfg.char_mode) begin
      pending_valid_next = 1'b0;
      if (printable) begin
        do_add = 1'b1;
      end else begin
        do_flush = 1'b1;
      end
    end else if (pending_valid && (s1_byte == ZERO_BYTE)) begin
      do_add             = 1'b1;
      add_pos            = pending_position;
      add_ns             = pending_nonspace;
      pending_valid_next = 1'b0;
    end else begin
      do_flush              = pending_valid || !printable;
      pending_valid_next    = printable;
      pending_nonspace_next = printable && nonspace;
      pending_position_next = printable ? byte_position : '0;
    end
  end

  // Run after an added character.
  always_comb begin
    rs_a = run_start;
    rl_a = run_length;
    rn_a = run_has_nonspace;
    if (do_add) begin
      if (run_length == '0) begin
        rs_a = add_pos;
      end
      if (run_length != LENGTH_MAX) begin
        rl_a = run_length + 1'b1;
      end
      rn_a = run_has_nonspace || add_ns;
    end
  end

  // The run is flushed either by the byte itself or by the end of stream;
  // at most one of the two can report it.
  always_comb begin
    if (do_flush) begin
      flush_start  = run_start;
      flush_length = run_length;
      flush_ns     = run_has_nonspace;
    end else begin
      flush_start  = rs_a;
      flush_length = rl_a;
      flush_ns     = rn_a;
    end
    hit = (do_flush || s1_eos) && (flush_length != '0) &&
          (flush_length >= min_len) && flush_ns;
    run_start_next        = rs_a;
    run_length_next       = (do_flush || s1_eos) ? '0 : rl_a;
    run_has_nonspace_next = (do_flush || s1_eos) ? 1'b0 : rn_a;
    found_count_next      = hit ? found_count + 1'b1 : found_count;
  end

  // Result of this step.
  always_comb begin
    res_valid        = step && (hit || s1_eos);
    res.string_found = hit;
    res.start_offset = hit ? flush_start : '0;
    res.char_count   = hit ? flush_length : '0;
    res.total_found  = found_count_next;
    res.stream_done  = s1_eos;
  end

  // State update; the final byte clears everything.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      run_start        <= '0;
      run_length       <= '0;
      run_has_nonspace <= 1'b0;
      pending_valid    <= 1'b0;
      pending_nonspace <= 1'b0;
      pending_position <= '0;
      found_count      <= '0;
    end else if (step) begin
      if (s1_eos) begin
        byte_position    <= '0;
        run_start        <= '0;
        run_length       <= '0;
        run_has_nonspace <= 1'b0;
        pending_valid    <= 1'b0;
        pending_nonspace <= 1'b0;
        pending_position <= '0;
        found_count      <= '0;
      end else begin
        byte_position    <= byte_position + 1'b1;
        run_start        <= run_start_next;
        run_length       <= run_length_next;
        run_has_nonspace <= run_has_nonspace_next;
        pending_valid    <= pending_valid_next;
        pending_nonspace <= pending_nonspace_next;
        pending_position <= pending_position_next;
        found_count      <= found_count_next;
      end
    end
  end

`ifndef SYNTH
  // The final byte leaves a cleared scanner behind.
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    step && s1_eos |=> (byte_position == '0) && (found_count == '0) && !pending_valid)
    else $error("state not cleared after end of stream");

  // State only moves when a byte is processed.
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(byte_position) && $stable(run_length) && $stable(found_count))
    else $error("scan state changed without a byte");

  // A reported run always meets the minimum length.
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.string_found |-> (res.char_count >= min_len) && (res.char_count != '0))
    else $error("reported run shorter than minimum");
`endif

endmodule

/* hdl/psrs_out.sv */
`timescale 1ns / 1ps

module psrs_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                res_valid,
  input  psrs_pkg::result_t                   res,
  output logic                                out_free,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                string_found,
  output logic [psrs_pkg::OFFSET_BITS-1:0]    start_offset,
  output logic [psrs_pkg::LENGTH_BITS-1:0]    char_count,
  output logic [psrs_pkg::COUNT_BITS-1:0]     total_found,
  output logic                                stream_done
);
  import psrs_pkg::*;

  result_t held;

  assign out_free = !out_valid || !out_stall;

  // Result register: loads whenever the current transaction leaves or none waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      held <= res;
    end
  end

  assign string_found = held.string_found;
  assign start_offset = held.start_offset;
  assign char_count   = held.char_count;
  assign total_found  = held.total_found;
  assign stream_done  = held.stream_done;

endmodule

/* test/printable_string_run_scanner_test.sv */
`timescale 1ns / 1ps

module printable_string_run_scanner_test;
  import psrs_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  // Register addresses on the configuration port.
  localparam logic [ADDR_BITS-1:0] ADDR_CHAR_MODE  = 3'd0;
  localparam logic [ADDR_BITS-1:0] ADDR_MIN_LENGTH = 3'd4;

  typedef enum logic {MODE_ASCII = 1'b0, MODE_UTF16 = 1'b1} char_mode_t;
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [7:0]            data;
    logic                  eos;
    bit                    typed;
    result_t               want;
    logic [ADDR_BITS-1:0]  addr;
    logic [31:0]           value;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_BITS-1:0]   paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             data_byte = '0;
  logic                   end_of_stream = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   string_found;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LENGTH_BITS-1:0] char_count;
  logic [COUNT_BITS-1:0]  total_found;
  logic                   stream_done;

  printable_string_run_scanner uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .end_of_stream(end_of_stream),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .string_found(string_found),
    .start_offset(start_offset),
    .char_count(char_count),
    .total_found(total_found),
    .stream_done(stream_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the configuration and the scan state.
  char_mode_t             cur_mode = MODE_ASCII;
  logic [7:0]             cur_min_len = 8'd4;
  logic [OFFSET_BITS-1:0] scan_pos = '0;
  logic [OFFSET_BITS-1:0] run_begin = '0;
  logic [LENGTH_BITS-1:0] run_len = '0;
  bit                     run_nonblank = 1'b0;
  bit                     pend_valid = 1'b0;
  bit                     pend_nonblank = 1'b0;
  logic [OFFSET_BITS-1:0] pend_pos = '0;
  logic [COUNT_BITS-1:0]  runs_found = '0;

  result_t   expected_reports[$];
  stim_row_t directed_rows[$];

  int  fail_count = 0;
  int  reports_checked = 0;
  int  strings_seen = 0;
  int  items_sent = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  hold_left = 0;
  bit  hold_go = 1'b0;

  char_mode_t  mode_plan[6] = '{MODE_UTF16, MODE_ASCII, MODE_ASCII,
                                MODE_UTF16, MODE_UTF16, MODE_ASCII};
  logic [7:0]  min_len_plan[6] = '{8'd1, 8'd16, 8'd1, 8'd12, 8'd3, 8'd6};

  // Appends one character to the current run; the length saturates.
  function automatic void add_to_run(input logic [OFFSET_BITS-1:0] pos, input bit nonblank);
    if (run_len == '0) run_begin = pos;
    if (run_len != LENGTH_MAX) run_len++;
    if (nonblank) run_nonblank = 1'b1;
  endfunction

  // Ends the current run and fills in a report if it qualifies.
  function automatic bit close_run(inout result_t res);
    bit hit;
    hit = (run_len != '0) && (run_len >= cur_min_len) && run_nonblank;
    if (hit) begin
      runs_found++;
      res.string_found = 1'b1;
      res.start_offset = run_begin;
      res.char_count   = run_len;
      res.total_found  = runs_found;
      res.stream_done  = 1'b0;
    end
    run_len = '0;
    run_nonblank = 1'b0;
    return hit;
  endfunction

  // Advances the scan by one byte; returns 1 when the byte causes a report.
  function automatic bit scan_byte(input logic [7:0] b, input logic eos, output result_t res);
    bit hit;
    bit printable;
    hit = 1'b0;
    res = '0;
    printable = (b >= FIRST_PRINTABLE) && (b <= LAST_PRINTABLE);
    if (cur_mode == MODE_ASCII) begin
      pend_valid = 1'b0;
      if (printable) add_to_run(scan_pos, b != SPACE_CHAR);
      else hit = close_run(res);
    end else if (pend_valid && b == ZERO_BYTE) begin
      add_to_run(pend_pos, pend_nonblank);
      pend_valid = 1'b0;
    end else begin
      // A failed pair ends the run; this byte may start a new pair.
      if (pend_valid || !printable) hit = close_run(res);
      pend_valid    = printable;
      pend_nonblank = printable && (b != SPACE_CHAR);
      pend_pos      = printable ? scan_pos : '0;
    end
    scan_pos = scan_pos + 1'b1;

    // The final byte flushes the run, always reports, and clears the state.
    if (eos) begin
      if (!hit) hit = close_run(res);
      if (!hit) res.total_found = runs_found;
      res.stream_done = 1'b1;
      scan_pos      = '0;
      run_begin     = '0;
      run_len       = '0;
      run_nonblank  = 1'b0;
      pend_valid    = 1'b0;
      pend_nonblank = 1'b0;
      pend_pos      = '0;
      runs_found    = '0;
      hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [7:0] printable_char();
    if ($urandom_range(3) == 0) return SPACE_CHAR;
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] other_byte();
    if ($urandom_range(1) == 0) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(127, 255));
  endfunction

  // Directed table builders.
  function automatic void add_byte(input logic [7:0] b, input logic eos);
    stim_row_t r;
    r = '{ROW_BYTE, b, eos, 1'b0, '0, '0, '0};
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_checked(input logic [7:0] b, input logic eos, input logic found,
                                      input logic [31:0] offset, input logic [15:0] count,
                                      input logic [31:0] total, input logic done);
    stim_row_t r;
    result_t   want;
    want.string_found = found;
    want.start_offset = offset;
    want.char_count   = count;
    want.total_found  = total;
    want.stream_done  = done;
    r = '{ROW_BYTE, b, eos, 1'b1, want, '0, '0};
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_cfg(input logic [ADDR_BITS-1:0] addr, input logic [31:0] value);
    stim_row_t r;
    r = '{ROW_CFG, '0, 1'b0, 1'b0, '0, addr, value};
    directed_rows = {directed_rows, r};
  endfunction

  // Offers one byte, holds it until taken, then records what it should cause.
  task automatic send_byte(input logic [7:0] b, input logic eos,
                           input bit typed = 1'b0, input result_t typed_res = '0);
    result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (scan_byte(b, eos, res) || typed) begin
      expected_reports = {expected_reports, typed ? typed_res : res};
    end
    items_sent++;
  endtask

  // Stops offering and waits until the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read back of the field.
  task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_CHAR_MODE) begin
      cur_mode = char_mode_t'(value[0]);
      if (readback[0] !== value[0]) begin
        $error("char_mode readback: expected %0h, got %0h", value[0], readback[0]);
        fail_count++;
      end
    end else begin
      cur_min_len = value[7:0];
      if (readback[7:0] !== value[7:0]) begin
        $error("min_length readback: expected %0h, got %0h", value[7:0], readback[7:0]);
        fail_count++;
      end
    end
  endtask

  task automatic apply_settings(input char_mode_t mode, input logic [7:0] min_len);
    settle();
    write_reg(ADDR_CHAR_MODE, {31'd0, mode});
    write_reg(ADDR_MIN_LENGTH, {24'd0, min_len});
    settings_used++;
  endtask

  // One random stretch of the stream: mostly a run of characters, usually
  // with an ending, sometimes plain noise.
  task automatic send_segment();
    int len;
    bit blank_only;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      return;
    end
    if ($urandom_range(7) == 0) len = int'(cur_min_len) + int'($urandom_range(0, 3)) - 1;
    else len = int'($urandom_range(0, 10));
    blank_only = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++) begin
      send_byte(blank_only ? SPACE_CHAR : printable_char(), 1'b0);
      if (cur_mode == MODE_UTF16) send_byte(ZERO_BYTE, 1'b0);
    end
    case ($urandom_range(3))
      0: send_byte(other_byte(), 1'b0);
      1: send_byte(printable_char(), 1'b0);
      2: send_byte(8'($urandom_range(255)), 1'b1);
      default: ;
    endcase
  endtask

  // Receiver side: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Each result transaction is compared with the oldest expected report.
  always @(posedge clk) begin : check_reports
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("result transaction with no report expected");
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("string_found", 64'(want.string_found), 64'(string_found));
        check_field("start_offset", 64'(want.start_offset), 64'(start_offset));
        check_field("char_count", 64'(want.char_count), 64'(char_count));
        check_field("total_found", 64'(want.total_found), 64'(total_found));
        check_field("stream_done", 64'(want.stream_done), 64'(stream_done));
        reports_checked++;
        if (string_found === 1'b1) strings_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int target;

    // ASCII mode at reset settings: a lone final byte reports nothing found.
    add_checked(8'hFF, 1'b1, 1'b0, 32'd0, 16'd0, 32'd0, 1'b1);
    // A run reaching the top printable code, ended by the first code above it.
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b0);
    add_byte(8'h43, 1'b0);
    add_byte(8'h44, 1'b0);
    add_byte(8'h7E, 1'b0);
    add_checked(8'h7F, 1'b0, 1'b1, 32'd0, 16'd5, 32'd1, 1'b0);
    // A long enough run of spaces only is not reported.
    add_byte(8'h20, 1'b0);
    add_byte(8'h20, 1'b0);
    add_byte(8'h20, 1'b0);
    add_byte(8'h20, 1'b0);
    add_byte(8'h1F, 1'b0);
    // A short run, a tab that ends it, and the final byte on the tab.
    add_byte(8'h48, 1'b0);
    add_checked(8'h09, 1'b1, 1'b0, 32'd0, 16'd0, 32'd1, 1'b1);
    // UTF-16LE with the smallest minimum length.
    add_cfg(ADDR_CHAR_MODE, {31'd0, MODE_UTF16});
    add_cfg(ADDR_MIN_LENGTH, 32'd1);
    add_byte(8'h41, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h20, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h42, 1'b0);
    // A failed pair ends the run and the byte starts a new pair.
    add_checked(8'h43, 1'b0, 1'b1, 32'd0, 16'd2, 32'd1, 1'b0);
    add_byte(8'h00, 1'b0);
    // A printable final byte is left pending and dropped at the flush.
    add_checked(8'h44, 1'b1, 1'b1, 32'd5, 16'd1, 32'd2, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].addr, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].eos,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random stream under three idle patterns and six register settings;
    // the scan state carries over each settings change.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 61 : 0;
      rx_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 23 : 0;
      for (int s = 0; s < 2; s++) begin
        apply_settings(mode_plan[phase * 2 + s], min_len_plan[phase * 2 + s]);
        target = items_sent + 70;
        while (items_sent < target) send_segment();
      end
    end

    // Receiver holds off while every byte ends a stream, so the block backs up.
    hold_go = 1'b1;
    repeat (40) send_byte(8'($urandom_range(255)), 1'b1);

    settle();
    $display("Scanned %0d bytes in ASCII and UTF-16LE modes under %0d register settings.",
             items_sent, settings_used);
    $display("Compared %0d results, %0d of them reporting a string.",
             reports_checked, strings_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
